@@ src/divider_and_reload_timer_core_defines.svh @@
// Assertion macros for the divider and reload timer.
// Used by the core top level; expects signals clk and rst in scope.
`ifndef DIVIDER_AND_RELOAD_TIMER_CORE_DEFINES_SVH
`define DIVIDER_AND_RELOAD_TIMER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define DRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define DRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/drt_pkg.sv @@
// Shared types and constants for the divider and reload timer.
// No dependencies.
package drt_pkg;

  // APB port geometry
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [1:0] CFG_CYCLES_PER_MS = 2'd0;
  localparam logic [1:0] CFG_DOUBLE_SPEED  = 2'd1;
  localparam logic [1:0] CFG_DIV_PERIOD    = 2'd2;

  // Configuration reset values
  localparam logic [15:0] RESET_CYCLES_PER_MS = 16'd4194;
  localparam logic [15:0] RESET_DIV_PERIOD    = 16'd256;

  // cycles_per_ms * 1000 fits in 26 bits
  localparam int          CPM_PROD_W = 26;
  localparam logic [9:0]  CPM_SCALE  = 10'd1000;

  // Item modes
  localparam logic [1:0] MODE_ADVANCE = 2'd0;
  localparam logic [1:0] MODE_READ    = 2'd1;
  localparam logic [1:0] MODE_WRITE   = 2'd2;

  // Timer register indexes
  localparam logic [1:0] REG_DIVIDER = 2'd0;
  localparam logic [1:0] REG_COUNTER = 2'd1;
  localparam logic [1:0] REG_RELOAD  = 2'd2;
  localparam logic [1:0] REG_CONTROL = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] reg_index;
    logic [7:0] write_byte;
    logic [7:0] elapsed_cycles;
  } drt_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
  } drt_out_t;

  // Configuration as seen by the step logic
  typedef struct packed {
    logic [CPM_PROD_W-1:0] cpm_x1000;
    logic                  double_speed;
    logic [15:0]           div_period;
  } drt_cfg_t;

endpackage

@@ src/divider_and_reload_timer_core.sv @@
// Channel  | valid     | stall     | payload
// input    | in_valid  | in_stall  | in_data  (drt_in_t: mode, reg_index, write_byte, elapsed_cycles)
// output   | out_valid | out_stall | out_data (drt_out_t: read_data, timer_irq)
// config   | APB write: psel & penable & pwrite & pready, registers at 4 * index
//
// One transaction per cycle while the result is not stalled; stages: input register, result register.
// The timer state updates in a single pass while the input register moves to the result
// register. Reset (rst, synchronous) empties both stages and restores the config and timer registers.
// A stalled result holds; the input register fills behind it, then in_stall rises.
// Depends on drt_pkg, drt_cfg, drt_step and divider_and_reload_timer_core_defines.svh.
`include "divider_and_reload_timer_core_defines.svh"

module divider_and_reload_timer_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  drt_pkg::drt_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output drt_pkg::drt_out_t               out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [drt_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [drt_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [drt_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import drt_pkg::*;

  drt_cfg_t cfg;
  drt_in_t  s1_item;
  drt_out_t step_result;
  logic     s1_valid;
  logic     advance;
  logic     step_en;

  drt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  drt_step u_step (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .item    (s1_item),
    .cfg     (cfg),
    .result  (step_result)
  );

  // Handshake
  assign advance  = !out_valid || !out_stall;
  assign step_en  = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) out_valid <= s1_valid;
      if (!in_stall) s1_valid <= in_valid;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s1_item <= in_data;
    if (step_en) out_data <= step_result;
  end

  `DRT_ASSERT_NOW(a_stall_cause, in_stall, s1_valid && out_valid && out_stall, "input stalled without a blocked result")
  `DRT_ASSERT_NEXT(a_step_delivers, step_en, out_valid, "processed transaction did not reach the result register")
  `DRT_ASSERT_NEXT(a_s1_holds, s1_valid && !advance, s1_valid && $stable(s1_item), "held input transaction changed")
  `DRT_ASSERT_NOW(a_irq_no_data, out_valid && out_data.timer_irq, out_data.read_data == 8'd0, "interrupt result carries read data")

endmodule

@@ src/drt_cfg.sv @@
// APB configuration registers and the cycles_per_ms * 1000 product.
// Depends on drt_pkg.
module drt_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [drt_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [drt_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [drt_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output drt_pkg::drt_cfg_t               cfg
);
  import drt_pkg::*;

  logic [15:0]           cycles_per_ms;
  logic                  double_speed;
  logic [15:0]           div_period;
  logic [CPM_PROD_W-1:0] cpm_x1000;
  logic                  wr_en;
  logic [1:0]            reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cycles_per_ms <= RESET_CYCLES_PER_MS;
      double_speed  <= 1'b0;
      div_period    <= RESET_DIV_PERIOD;
    end else if (wr_en) begin
      unique case (reg_sel)
        CFG_CYCLES_PER_MS: cycles_per_ms <= pwdata[15:0];
        CFG_DOUBLE_SPEED:  double_speed  <= pwdata[0];
        CFG_DIV_PERIOD:    div_period    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Scaled rate, follows the register directly
  assign cpm_x1000 = CPM_PROD_W'(cycles_per_ms) * CPM_PROD_W'(CPM_SCALE);

  // Read back
  always_comb begin
    unique case (reg_sel)
      CFG_CYCLES_PER_MS: prdata = APB_DATA_W'(cycles_per_ms);
      CFG_DOUBLE_SPEED:  prdata = APB_DATA_W'(double_speed);
      CFG_DIV_PERIOD:    prdata = APB_DATA_W'(div_period);
      default:           prdata = '0;
    endcase
  end

  assign cfg = '{cpm_x1000: cpm_x1000, double_speed: double_speed, div_period: div_period};

endmodule

@@ src/drt_step.sv @@
// Timer state registers and the single-pass update for one transaction.
// Depends on drt_pkg.
module drt_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                step_en,
  input  drt_pkg::drt_in_t    item,
  input  drt_pkg::drt_cfg_t   cfg,
  output drt_pkg::drt_out_t   result
);
  import drt_pkg::*;

  localparam int              ACC_W   = 17;
  localparam int              TICK_W  = 14;
  localparam logic [ACC_W:0]  ACC_MAX = 18'h1FFFF;

  typedef struct packed {
    logic             hit;
    logic [ACC_W-1:0] acc;
  } acc_res_t;

  // Add cycles, take one period off when reached, saturate
  function automatic acc_res_t accumulate(input logic [ACC_W-1:0] acc,
                                          input logic [7:0]       cycles,
                                          input logic [ACC_W-1:0] period);
    logic [ACC_W:0] sum;
    acc_res_t       res;
    sum     = {1'b0, acc} + (ACC_W+1)'(cycles);
    res.hit = (sum >= {1'b0, period});
    if (res.hit) sum = sum - {1'b0, period};
    if (sum > ACC_MAX) sum = ACC_MAX;
    res.acc = sum[ACC_W-1:0];
    return res;
  endfunction

  logic [7:0]       divider, divider_next;
  logic [7:0]       counter, counter_next;
  logic [7:0]       reload_value, reload_value_next;
  logic [7:0]       control, control_next;
  logic [ACC_W-1:0] divider_accum, divider_accum_next;
  logic [ACC_W-1:0] counter_accum, counter_accum_next;

  logic [4:0]            tick_shift;
  logic [CPM_PROD_W-1:0] tick_full;
  logic [TICK_W-1:0]     tick_period;
  logic [7:0]            counter_inc;
  acc_res_t              div_res;
  acc_res_t              cnt_res;

  // Tick period from the control rate select and speed mode
  always_comb begin
    case (control[1:0])
      2'd0:    tick_shift = 5'd12;
      2'd1:    tick_shift = 5'd18;
      2'd2:    tick_shift = 5'd16;
      default: tick_shift = 5'd14;
    endcase
    tick_full   = cfg.cpm_x1000 >> (tick_shift + 5'(cfg.double_speed));
    tick_period = tick_full[TICK_W-1:0];
  end

  assign div_res     = accumulate(divider_accum, item.elapsed_cycles, ACC_W'(cfg.div_period));
  assign cnt_res     = accumulate(counter_accum, item.elapsed_cycles, ACC_W'(tick_period));
  assign counter_inc = counter + 8'd1;

  // Next state and result
  always_comb begin
    divider_next       = divider;
    counter_next       = counter;
    reload_value_next  = reload_value;
    control_next       = control;
    divider_accum_next = divider_accum;
    counter_accum_next = counter_accum;
    result             = '0;
    case (item.mode)
      MODE_ADVANCE: begin
        divider_accum_next = div_res.acc;
        if (div_res.hit) divider_next = divider + 8'd1;
        if (control[2]) begin
          counter_accum_next = cnt_res.acc;
          if (cnt_res.hit) begin
            if (counter_inc == 8'd0) begin
              counter_next     = reload_value;
              result.timer_irq = 1'b1;
            end else begin
              counter_next = counter_inc;
            end
          end
        end
      end
      MODE_READ: begin
        unique case (item.reg_index)
          REG_DIVIDER: result.read_data = divider;
          REG_COUNTER: result.read_data = counter;
          REG_RELOAD:  result.read_data = reload_value;
          REG_CONTROL: result.read_data = control;
          default:     result.read_data = '0;
        endcase
      end
      MODE_WRITE: begin
        unique case (item.reg_index)
          REG_DIVIDER: divider_next      = '0;
          REG_COUNTER: counter_next      = item.write_byte;
          REG_RELOAD:  reload_value_next = item.write_byte;
          REG_CONTROL: control_next      = item.write_byte;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      divider       <= '0;
      counter       <= '0;
      reload_value  <= '0;
      control       <= '0;
      divider_accum <= '0;
      counter_accum <= '0;
    end else if (step_en) begin
      divider       <= divider_next;
      counter       <= counter_next;
      reload_value  <= reload_value_next;
      control       <= control_next;
      divider_accum <= divider_accum_next;
      counter_accum <= counter_accum_next;
    end
  end

endmodule

@@ tb/divider_and_reload_timer_core_test.sv @@
// Self-checking testbench for divider_and_reload_timer_core: a cycle-free timer mirror
// predicts every transaction, and the results are checked in order under random backpressure.
// Depends on drt_pkg and the core RTL only.
module divider_and_reload_timer_core_test;
  import drt_pkg::*;

  // Mode 3 is legal on the wire but does nothing
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int unsigned ACCUM_MAX = 32'h1FFFF;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TIMEOUT_CYCLES = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  drt_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  drt_out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  // Timer mirror: configuration and register state
  logic [15:0] cpm_cfg;
  logic        dbl_speed_cfg;
  logic [15:0] div_period_cfg;
  logic [7:0]  div_reg;
  logic [7:0]  tima_reg;
  logic [7:0]  tma_reg;
  logic [7:0]  tac_reg;
  int unsigned div_accum;
  int unsigned tima_accum;

  drt_out_t timer_results_due[$];
  int mismatch_count = 0;
  bit idling_on = 1'b0;
  int stall_left = 0;

  divider_and_reload_timer_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #6 clk = ~clk;

  // Mostly no gap, sometimes short, rarely long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idling_on || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_error(input string what, input int unsigned want, input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s: expected %0h, got %0h", $time, what, want, got);
  endtask

  // Tick period from the clock select in TAC bits 1..0, halved in double speed
  function automatic int unsigned tick_period();
    int unsigned prod;
    prod = 32'(cpm_cfg) * 32'd1000;
    case (tac_reg[1:0])
      2'd0:    prod = prod >> 12;
      2'd1:    prod = prod >> 18;
      2'd2:    prod = prod >> 16;
      default: prod = prod >> 14;
    endcase
    if (dbl_speed_cfg) prod = prod >> 1;
    return prod;
  endfunction

  // At most one period per advance; saturate at the accumulator width
  task automatic add_cycles(inout int unsigned accum, input int unsigned cycles,
                            input int unsigned period, output bit hit);
    int unsigned sum;
    sum = accum + cycles;
    hit = (sum >= period);
    if (hit) sum = sum - period;
    if (sum > ACCUM_MAX) sum = ACCUM_MAX;
    accum = sum;
  endtask

  // Update the mirror for one transaction and return the result it must produce
  task automatic apply_timer_item(input drt_in_t item, output drt_out_t res);
    bit div_hit;
    bit tima_hit;
    res = '0;
    case (item.mode)
      MODE_ADVANCE: begin
        add_cycles(div_accum, 32'(item.elapsed_cycles), 32'(div_period_cfg), div_hit);
        if (div_hit) div_reg = div_reg + 8'd1;
        if (tac_reg[2]) begin
          add_cycles(tima_accum, 32'(item.elapsed_cycles), tick_period(), tima_hit);
          if (tima_hit) begin
            if (tima_reg == 8'hFF) begin
              tima_reg = tma_reg;
              res.timer_irq = 1'b1;
            end else begin
              tima_reg = tima_reg + 8'd1;
            end
          end
        end
      end
      MODE_READ: begin
        case (item.reg_index)
          REG_DIVIDER: res.read_data = div_reg;
          REG_COUNTER: res.read_data = tima_reg;
          REG_RELOAD:  res.read_data = tma_reg;
          default:     res.read_data = tac_reg;
        endcase
      end
      MODE_WRITE: begin
        case (item.reg_index)
          REG_DIVIDER: div_reg = 8'h00;
          REG_COUNTER: tima_reg = item.write_byte;
          REG_RELOAD:  tma_reg = item.write_byte;
          default:     tac_reg = item.write_byte;
        endcase
      end
      default: ;
    endcase
  endtask

  function automatic drt_in_t mk_item(input logic [1:0] mode, input logic [1:0] index,
                                      input logic [7:0] wdata, input logic [7:0] cycles);
    drt_in_t item;
    item.mode = mode;
    item.reg_index = index;
    item.write_byte = wdata;
    item.elapsed_cycles = cycles;
    return item;
  endfunction

  // Send one transaction after an optional gap; predict it once accepted
  task automatic send_item(input drt_in_t item);
    int gap;
    drt_out_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    apply_timer_item(item, res);
    timer_results_due.push_back(res);
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (timer_results_due.size() != 0) @(posedge clk);
    // two-stage pipeline: let it settle before touching config
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input logic [1:0] index, input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      CFG_CYCLES_PER_MS: cpm_cfg = value;
      CFG_DOUBLE_SPEED:  dbl_speed_cfg = value[0];
      CFG_DIV_PERIOD:    div_period_cfg = value;
      default: ;
    endcase
  endtask

  task automatic set_timer_config(input logic [15:0] cpm, input logic dbl,
                                  input logic [15:0] divp);
    wait_until_drained();
    write_config(CFG_CYCLES_PER_MS, cpm);
    write_config(CFG_DOUBLE_SPEED, {15'h0, dbl});
    write_config(CFG_DIV_PERIOD, divp);
  endtask

  // Mostly advances, reads and writes; writes steer the counter toward wraps
  function automatic drt_in_t random_item();
    drt_in_t item;
    int r;
    item.reg_index = 2'($urandom_range(0, 3));
    item.write_byte = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 8) item.elapsed_cycles = 8'h00;
    else if (r < 16) item.elapsed_cycles = 8'hFF;
    else item.elapsed_cycles = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 50) item.mode = MODE_ADVANCE;
    else if (r < 70) item.mode = MODE_READ;
    else if (r < 95) item.mode = MODE_WRITE;
    else item.mode = MODE_NONE;
    if (item.mode == MODE_WRITE && item.reg_index == REG_CONTROL && $urandom_range(0, 3) != 0)
      item.write_byte[2] = 1'b1;
    if (item.mode == MODE_WRITE && item.reg_index == REG_COUNTER && $urandom_range(0, 1) == 1)
      item.write_byte = 8'($urandom_range(240, 255));
    return item;
  endfunction

  // Result checker and random output stall
  always @(posedge clk) begin : check_results
    drt_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (timer_results_due.size() == 0) begin
          report_error("result with none expected", 0, 32'(out_data));
        end else begin
          want = timer_results_due.pop_front();
          if (out_data.read_data !== want.read_data)
            report_error("read_data", 32'(want.read_data), 32'(out_data.read_data));
          if (out_data.timer_irq !== want.timer_irq)
            report_error("timer_irq", 32'(want.timer_irq), 32'(out_data.timer_irq));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = (idling_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  task automatic test_reset_values();
    send_item(mk_item(MODE_READ, REG_DIVIDER, 8'h00, 8'h00));
    send_item(mk_item(MODE_READ, REG_COUNTER, 8'hFF, 8'hFF));
    send_item(mk_item(MODE_READ, REG_RELOAD, 8'h00, 8'h00));
    send_item(mk_item(MODE_READ, REG_CONTROL, 8'h00, 8'h00));
  endtask

  // Divider write clears whatever the byte; control keeps all 8 bits
  task automatic test_register_writes();
    send_item(mk_item(MODE_WRITE, REG_DIVIDER, 8'hFF, 8'h00));
    send_item(mk_item(MODE_WRITE, REG_COUNTER, 8'hFE, 8'h00));
    send_item(mk_item(MODE_WRITE, REG_RELOAD, 8'hA5, 8'h00));
    send_item(mk_item(MODE_WRITE, REG_CONTROL, 8'hFD, 8'h00));
    send_item(mk_item(MODE_READ, REG_CONTROL, 8'h00, 8'h00));
    send_item(mk_item(MODE_READ, REG_RELOAD, 8'h00, 8'h00));
    send_item(mk_item(MODE_READ, REG_DIVIDER, 8'h00, 8'h00));
  endtask

  // Two full advances: one tick to 0xFF, one wrap with reload and interrupt
  task automatic test_counter_wrap();
    send_item(mk_item(MODE_ADVANCE, REG_DIVIDER, 8'h00, 8'hFF));
    send_item(mk_item(MODE_ADVANCE, REG_CONTROL, 8'hFF, 8'hFF));
    send_item(mk_item(MODE_READ, REG_COUNTER, 8'h00, 8'h00));
    send_item(mk_item(MODE_READ, REG_DIVIDER, 8'h00, 8'h00));
  endtask

  // Timer stopped holds the counter; mode 3 does nothing
  task automatic test_timer_stopped();
    send_item(mk_item(MODE_WRITE, REG_CONTROL, 8'h03, 8'h00));
    send_item(mk_item(MODE_ADVANCE, REG_COUNTER, 8'h00, 8'hFF));
    send_item(mk_item(MODE_READ, REG_COUNTER, 8'h00, 8'h00));
    send_item(mk_item(MODE_NONE, REG_CONTROL, 8'hFF, 8'hFF));
  endtask

  // Tick period shifts to zero: every advance ticks, even one of zero cycles
  task automatic test_zero_tick_period();
    set_timer_config(16'd1, 1'b1, 16'd1);
    send_item(mk_item(MODE_WRITE, REG_CONTROL, 8'h04, 8'h00));
    send_item(mk_item(MODE_ADVANCE, REG_DIVIDER, 8'h00, 8'h00));
    send_item(mk_item(MODE_ADVANCE, REG_DIVIDER, 8'h00, 8'h00));
    send_item(mk_item(MODE_WRITE, REG_COUNTER, 8'hFF, 8'h00));
    send_item(mk_item(MODE_ADVANCE, REG_DIVIDER, 8'h00, 8'h00));
    send_item(mk_item(MODE_READ, REG_COUNTER, 8'h00, 8'h00));
  endtask

  task automatic run_traffic_phase(input logic [15:0] cpm, input logic dbl,
                                   input logic [15:0] divp, input int count,
                                   input bit with_idling, input int drain_at);
    logic [7:0] ctl;
    set_timer_config(cpm, dbl, divp);
    idling_on = with_idling;
    // start each phase with the timer running at a random clock select
    ctl = 8'($urandom_range(0, 255));
    ctl[2] = 1'b1;
    send_item(mk_item(MODE_WRITE, REG_CONTROL, ctl, 8'h00));
    for (int i = 0; i < count; i++) begin
      if (i == drain_at) wait_until_drained();
      send_item(random_item());
    end
  endtask

  // Config sweep over extremes and random settings
  task automatic test_random_traffic();
    run_traffic_phase(RESET_CYCLES_PER_MS, 1'b0, RESET_DIV_PERIOD, 180, 1'b1, -1);
    run_traffic_phase(16'd1, 1'b0, 16'd1, 180, 1'b1, -1);
    run_traffic_phase(16'hFFFF, 1'b1, 16'hFFFF, 180, 1'b1, 90);
    run_traffic_phase(16'hFFFF, 1'b0, 16'd1, 180, 1'b0, -1);
    run_traffic_phase(16'd1, 1'b1, 16'hFFFF, 180, 1'b1, -1);
    run_traffic_phase(16'($urandom_range(1, 65535)), 1'($urandom_range(0, 1)),
                      16'($urandom_range(1, 65535)), 180, 1'b1, -1);
    run_traffic_phase(16'($urandom_range(1, 2000)), 1'($urandom_range(0, 1)),
                      16'($urandom_range(1, 600)), 180, 1'b1, -1);
  endtask

  initial begin : main_seq
    int drain_cycles;
    cpm_cfg = RESET_CYCLES_PER_MS;
    dbl_speed_cfg = 1'b0;
    div_period_cfg = RESET_DIV_PERIOD;
    div_reg = 8'h00;
    tima_reg = 8'h00;
    tma_reg = 8'h00;
    tac_reg = 8'h00;
    div_accum = 0;
    tima_accum = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_register_writes();
    test_counter_wrap();
    test_timer_stopped();
    test_zero_tick_period();
    test_random_traffic();

    // drain, then give late or extra results time to show up
    in_valid <= 1'b0;
    drain_cycles = 0;
    while (timer_results_due.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (10) @(posedge clk);
    if (timer_results_due.size() != 0)
      report_error("results never delivered", 0, timer_results_due.size());
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(12 * TIMEOUT_CYCLES);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ divider_and_reload_timer_core.f @@
+incdir+src
src/drt_pkg.sv
src/drt_cfg.sv
src/drt_step.sv
src/divider_and_reload_timer_core.sv
tb/divider_and_reload_timer_core_test.sv
